// File: design/fdp_pkg.sv
`timescale 1ns / 1ps

package fdp_pkg;

   localparam int TimeWidth  = 64;
   localparam int RateWidth  = 16;
   localparam int StepWidth  = 30;
   localparam int IterWidth  = 7;
   localparam int CsrIdxWidth = 8;
   localparam int ReqWidth   = 80;
   localparam int RspWidth   = 136;

   localparam logic [StepWidth-1:0] NS_PER_SECOND = 30'd1000000000;
   localparam logic [IterWidth-1:0] STEP_DIV_ITERS = 7'd30;
   localparam logic [IterWidth-1:0] SKIP_MOD_ITERS = 7'd64;

   localparam logic [CsrIdxWidth-1:0] CSR_MIN_RATE = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_RATE = 8'd1;

   localparam logic [RateWidth-1:0] MIN_RATE_RESET = 16'd1;
   localparam logic [RateWidth-1:0] MAX_RATE_RESET = 16'd1000;

   typedef struct packed {
      logic                 start;
      logic [IterWidth-1:0] iters;
   } div_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_FIRST,
      ST_MOD,
      ST_SKIP,
      ST_ADV,
      ST_OUT
   } state_type;

endpackage

// File: design/fdp_divider.sv
`timescale 1ns / 1ps

module fdp_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  fdp_pkg::div_req_type            req,
   input  logic [fdp_pkg::TimeWidth-1:0]   dividend,
   input  logic [fdp_pkg::StepWidth-1:0]   divisor,
   output logic                            done,
   output logic [fdp_pkg::TimeWidth-1:0]   quotient,
   output logic [fdp_pkg::StepWidth-1:0]   remainder
);
   import fdp_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [IterWidth-1:0] cnt_ff, cnt_in;
   logic [TimeWidth-1:0] dvd_ff, dvd_in;
   logic [StepWidth-1:0] dvs_ff, dvs_in;
   logic [StepWidth-1:0] rem_ff, rem_in;
   logic [StepWidth+1:0] trial;

   // one restoring step per cycle, quotient bits shift in at the bottom
   assign trial = {1'b0, rem_ff, dvd_ff[TimeWidth-1]} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.iters;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (!trial[StepWidth+1]) begin
            rem_in = trial[StepWidth-1:0];
            dvd_in = {dvd_ff[TimeWidth-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[StepWidth-2:0], dvd_ff[TimeWidth-1]};
            dvd_in = {dvd_ff[TimeWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - IterWidth'(1);
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

// File: design/frame_deadline_pacer.sv
`timescale 1ns / 1ps
// each request goes to ST_CHECK, then for a rate out of bounds straight to ST_OUT,
// while the deadline is ahead to ST_ADV, on a start or rate change to ST_DIV (30-step
// interval division) and ST_FIRST, and once the deadline is reached or passed to ST_MOD
// (64-step remainder for the skip), ST_SKIP and ST_ADV, all then to ST_OUT; one request
// at a time: the next is taken after the result is registered, ST_OUT waiting while the
// last is not taken; reset (synchronous) stops pacing, sets min_rate 1 and max_rate 1000
module frame_deadline_pacer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // now_ns[63:0], rate[79:64]
   input  logic [fdp_pkg::ReqWidth-1:0]      req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // paced[0], seen_time[64:1], wait_until[128:65], first[129], missed[130]
   output logic [fdp_pkg::RspWidth-1:0]      rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fdp_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [fdp_pkg::RateWidth-1:0]     csr_data
);
   import fdp_pkg::*;

   state_type            state_ff, state_in;
   logic [TimeWidth-1:0] now_ff, now_in;
   logic [RateWidth-1:0] rate_ff, rate_in;
   logic                 running_ff, running_in;
   logic [RateWidth-1:0] active_ff, active_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic [TimeWidth-1:0] nd_ff, nd_in;
   logic [TimeWidth-1:0] base_ff, base_in;
   logic                 res_paced_ff, res_paced_in;
   logic                 res_first_ff, res_first_in;
   logic                 res_missed_ff, res_missed_in;
   logic [TimeWidth-1:0] res_deadline_ff, res_deadline_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [RspWidth-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic [RateWidth-1:0] min_rate_ff, max_rate_ff;

   div_req_type          div_req;
   logic [TimeWidth-1:0] div_dividend;
   logic [StepWidth-1:0] div_divisor;
   logic                 div_done;
   logic [TimeWidth-1:0] div_quotient;
   logic [StepWidth-1:0] div_remainder;
   logic                 out_of_range;

   function automatic logic [TimeWidth-1:0] sat_add(input logic [TimeWidth-1:0] a,
                                                    input logic [StepWidth-1:0] b);
      logic [TimeWidth:0] s;
      s = {1'b0, a} + {{(TimeWidth-StepWidth+1){1'b0}}, b};
      sat_add = s[TimeWidth] ? '1 : s[TimeWidth-1:0];
   endfunction

   fdp_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .req       (div_req),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign out_of_range = (rate_ff == '0) || (rate_ff < min_rate_ff) || (rate_ff > max_rate_ff);

   always_comb begin
      state_in        = state_ff;
      now_in          = now_ff;
      rate_in         = rate_ff;
      running_in      = running_ff;
      active_in       = active_ff;
      step_in         = step_ff;
      nd_in           = nd_ff;
      base_in         = base_ff;
      res_paced_in    = res_paced_ff;
      res_first_in    = res_first_ff;
      res_missed_in   = res_missed_ff;
      res_deadline_in = res_deadline_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in    = rsp_tdata_ff;
      div_req.start   = 1'b0;
      div_req.iters   = SKIP_MOD_ITERS;
      div_dividend    = now_ff - nd_ff;
      div_divisor     = step_ff;
      req_tready      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               now_in   = req_tdata[TimeWidth-1:0];
               rate_in  = req_tdata[TimeWidth+RateWidth-1:TimeWidth];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            res_paced_in    = 1'b1;
            res_first_in    = 1'b0;
            res_missed_in   = 1'b0;
            res_deadline_in = '0;
            if (out_of_range) begin
               running_in   = 1'b0;
               active_in    = '0;
               nd_in        = '0;
               res_paced_in = 1'b0;
               state_in     = ST_OUT;
            end else if (!running_ff || active_ff != rate_ff) begin
               // interval = 1e9 / rate, dividend placed in the top bits
               div_req.start = 1'b1;
               div_req.iters = STEP_DIV_ITERS;
               div_dividend  = {NS_PER_SECOND, {(TimeWidth-StepWidth){1'b0}}};
               div_divisor   = {{(StepWidth-RateWidth){1'b0}}, rate_ff};
               state_in      = ST_DIV;
            end else if (now_ff >= nd_ff) begin
               div_req.start = 1'b1;
               state_in      = ST_MOD;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               step_in  = div_quotient[StepWidth-1:0];
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            running_in   = 1'b1;
            active_in    = rate_ff;
            nd_in        = sat_add(now_ff, step_ff);
            res_first_in = 1'b1;
            state_in     = ST_OUT;
         end
         ST_MOD: begin
            // skipping whole intervals lands on now minus the remainder
            if (div_done) begin
               base_in       = now_ff - {{(TimeWidth-StepWidth){1'b0}}, div_remainder};
               res_missed_in = 1'b1;
               state_in      = ST_SKIP;
            end
         end
         ST_SKIP: begin
            nd_in    = sat_add(base_ff, step_ff);
            state_in = ST_ADV;
         end
         ST_ADV: begin
            res_deadline_in = nd_ff;
            nd_in           = sat_add(nd_ff, step_ff);
            state_in        = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {5'b00000, res_missed_ff, res_first_ff, res_deadline_ff,
                                res_paced_ff ? now_ff : {TimeWidth{1'b0}}, res_paced_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         running_ff    <= 1'b0;
         active_ff     <= '0;
         nd_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
         min_rate_ff   <= MIN_RATE_RESET;
         max_rate_ff   <= MAX_RATE_RESET;
      end else begin
         state_ff      <= state_in;
         running_ff    <= running_in;
         active_ff     <= active_in;
         nd_ff         <= nd_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_index == CSR_MIN_RATE) begin
            min_rate_ff <= csr_data;
         end
         if (csr_valid && csr_index == CSR_MAX_RATE) begin
            max_rate_ff <= csr_data;
         end
      end
      now_ff          <= now_in;
      rate_ff         <= rate_in;
      step_ff         <= step_in;
      base_ff         <= base_in;
      res_paced_ff    <= res_paced_in;
      res_first_ff    <= res_first_in;
      res_missed_ff   <= res_missed_in;
      res_deadline_ff <= res_deadline_in;
      rsp_tdata_ff    <= rsp_tdata_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in flight");

   a_running_rate: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (active_ff != '0) && (step_ff != '0))
      else $error("pacing active without a valid rate or interval");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV) || (state_ff == ST_MOD))
      else $error("divider finished outside a waiting state");

   a_unpaced_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tdata_ff[0]) |-> (rsp_tdata_ff == '0))
      else $error("unpaced result carries nonzero fields");

endmodule
